// File: src/nir_pkg.sv
// Shared types and constants for the NEC infrared receiver with learning mode.
// Used by every module of the block; depends on nothing.
package nir_pkg;

	localparam int unsigned MAX_SYMBOLS_DEF = 256;
	localparam int unsigned DATA_BITS_DEF = 32;
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned DUR_W = 15;
	localparam int unsigned SEC_W = 8;
	localparam int unsigned CODE_W = 32;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [DUR_W-1:0] REPEAT_MARK_RST = 15'd8000;
	localparam logic [DUR_W-1:0] REPEAT_SPACE_RST = 15'd2000;
	localparam logic [DUR_W-1:0] HEADER_MARK_RST = 15'd4000;
	localparam logic [DUR_W-1:0] HEADER_SPACE_RST = 15'd4000;
	localparam logic [DUR_W-1:0] ONE_SPACE_RST = 15'd1000;
	localparam logic [SEC_W-1:0] LEARN_TIMEOUT_RST = 8'd15;
	localparam logic [SEC_W-1:0] COUNTDOWN_RST = 8'd15;

	typedef enum logic [2:0] {
		KIND_REPEAT = 3'd0,
		KIND_RECEIVED = 3'd1,
		KIND_LEARNED = 3'd2,
		KIND_COUNTDOWN = 3'd3,
		KIND_TIMEOUT = 3'd4
	} nir_kind_t;

	typedef enum logic [1:0] {
		OP_SYMBOL = 2'd0,
		OP_TICK = 2'd1,
		OP_START = 2'd2
	} nir_op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_REPEAT_MARK = 3'd0,
		REG_REPEAT_SPACE = 3'd1,
		REG_HEADER_MARK = 3'd2,
		REG_HEADER_SPACE = 3'd3,
		REG_ONE_SPACE = 3'd4,
		REG_LEARN_TIMEOUT = 3'd5
	} nir_reg_t;

	typedef struct packed {
		logic [DUR_W-1:0] repeat_mark_min;
		logic [DUR_W-1:0] repeat_space_min;
		logic [DUR_W-1:0] header_mark_min;
		logic [DUR_W-1:0] header_space_min;
		logic [DUR_W-1:0] one_space_min;
		logic [SEC_W-1:0] learn_timeout_seconds;
	} nir_cfg_t;

	typedef struct packed {
		nir_op_t op;
		logic rep_ok;
		logic data_ok;
		logic bit_one;
		logic last;
	} nir_item_t;

	typedef struct packed {
		logic [QCNT_W-1:0] count;
		logic full;
		logic empty;
	} nir_qstat_t;

endpackage

// File: src/nir_front.sv
// Front end: accepts input transfers, drops unused opcodes and compares the
// symbol durations against the thresholds. Depends on nir_pkg.
module nir_front (
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [31:0]                 s_axis_tdata,
	input  logic [1:0]                  s_axis_tuser,
	input  logic                        s_axis_tlast,
	input  nir_pkg::nir_cfg_t           cfg,
	input  nir_pkg::nir_qstat_t         qstat,
	output logic                        push,
	output nir_pkg::nir_item_t          push_item
);
	import nir_pkg::*;

	logic [DUR_W-1:0] mark_us;
	logic [DUR_W-1:0] space_us;
	logic             op_known;

	assign mark_us = s_axis_tdata[DUR_W-1:0];
	assign space_us = s_axis_tdata[2*DUR_W-1:DUR_W];
	assign s_axis_tready = !qstat.full;

	always_comb begin
		unique case (s_axis_tuser)
			OP_SYMBOL, OP_TICK, OP_START: op_known = 1'b1;
			default: op_known = 1'b0;
		endcase
	end

	assign push = s_axis_tvalid && s_axis_tready && op_known;

	always_comb begin
		push_item.op = nir_op_t'(s_axis_tuser);
		push_item.rep_ok = (mark_us > cfg.repeat_mark_min) && (space_us > cfg.repeat_space_min);
		push_item.data_ok = (mark_us > cfg.header_mark_min) && (space_us > cfg.header_space_min);
		push_item.bit_one = space_us > cfg.one_space_min;
		push_item.last = s_axis_tlast;
	end

endmodule

// File: src/nir_queue.sv
// Short queue of classified items between the front end and the back end.
// Depends on nir_pkg.
module nir_queue #(
	parameter int unsigned DEPTH = nir_pkg::QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  nir_pkg::nir_item_t   push_item,
	input  logic                 pop,
	output nir_pkg::nir_item_t   head,
	output nir_pkg::nir_qstat_t  qstat
);
	import nir_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	nir_item_t          entry_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	assign head = entry_q[rd_ptr_q];

	always_comb begin
		qstat.count = QCNT_W'(count_q);
		qstat.full = (count_q == CNT_W'(DEPTH));
		qstat.empty = (count_q == '0);
	end

endmodule

// File: src/nir_back.sv
// Back end: frame, learning and countdown state, and the output register.
// Depends on nir_pkg; takes items from nir_queue.
module nir_back #(
	parameter int unsigned MAX_SYMBOLS = nir_pkg::MAX_SYMBOLS_DEF,
	parameter int unsigned DATA_BITS = nir_pkg::DATA_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  nir_pkg::nir_cfg_t    cfg,
	input  nir_pkg::nir_item_t   head,
	input  nir_pkg::nir_qstat_t  qstat,
	output logic                 pop,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [39:0]          m_axis_tdata,
	output logic [2:0]           m_axis_tuser
);
	import nir_pkg::*;

	localparam int unsigned CNT_W = $clog2(MAX_SYMBOLS + 1);

	logic                 learning_q;
	logic [SEC_W-1:0]     countdown_q;
	logic [CNT_W-1:0]     count_q;
	logic                 rep_hdr_q;
	logic                 data_hdr_q;
	logic [DATA_BITS-1:0] shift_q;

	logic                 out_valid_q;
	nir_kind_t            out_kind_q;
	logic [CODE_W-1:0]    out_code_q;
	logic [SEC_W-1:0]     out_secs_q;

	logic [CNT_W-1:0]     cnt_inc;
	logic                 rep_nxt;
	logic                 data_nxt;
	logic [DATA_BITS-1:0] set_mask;
	logic [DATA_BITS-1:0] shift_nxt;
	logic [SEC_W-1:0]     cd_dec;

	logic                 res_valid;
	nir_kind_t            res_kind;
	logic [CODE_W-1:0]    res_code;
	logic [SEC_W-1:0]     res_secs;
	logic                 frame_end;
	logic                 learn_end;

	assign pop = !qstat.empty && (!out_valid_q || m_axis_tready);

	always_comb begin
		cnt_inc = (count_q < CNT_W'(MAX_SYMBOLS)) ? count_q + CNT_W'(1) : count_q;
		rep_nxt = (count_q == '0) ? head.rep_ok : rep_hdr_q;
		data_nxt = (count_q == '0) ? head.data_ok : data_hdr_q;
		for (int i = 0; i < DATA_BITS; i++) begin
			set_mask[i] = head.bit_one && (count_q == CNT_W'(i + 1));
		end
		shift_nxt = shift_q | set_mask;
		cd_dec = (countdown_q != '0) ? countdown_q - SEC_W'(1) : '0;
	end

	always_comb begin
		res_valid = 1'b0;
		res_kind = KIND_REPEAT;
		res_code = '0;
		res_secs = '0;
		frame_end = 1'b0;
		learn_end = 1'b0;
		unique case (head.op)
			OP_TICK: begin
				if (learning_q) begin
					res_valid = 1'b1;
					if (cd_dec != '0) begin
						res_kind = KIND_COUNTDOWN;
						res_secs = cd_dec;
					end else begin
						res_kind = KIND_TIMEOUT;
						learn_end = 1'b1;
					end
				end
			end
			OP_SYMBOL: begin
				frame_end = head.last;
				if (head.last) begin
					if (cnt_inc == CNT_W'(2) && rep_nxt) begin
						res_valid = 1'b1;
						res_kind = KIND_REPEAT;
					end else if (cnt_inc >= CNT_W'(DATA_BITS + 2) && data_nxt) begin
						res_valid = 1'b1;
						res_code = CODE_W'(shift_nxt);
						if (learning_q) begin
							res_kind = KIND_LEARNED;
							learn_end = 1'b1;
						end else begin
							res_kind = KIND_RECEIVED;
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			learning_q <= 1'b0;
			countdown_q <= COUNTDOWN_RST;
			count_q <= '0;
			rep_hdr_q <= 1'b0;
			data_hdr_q <= 1'b0;
			shift_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= pop ? res_valid : (out_valid_q && !m_axis_tready);
			if (pop) begin
				if (head.op == OP_TICK && learning_q) begin
					countdown_q <= cd_dec;
				end
				if (head.op == OP_START) begin
					learning_q <= 1'b1;
					countdown_q <= cfg.learn_timeout_seconds;
				end else if (learn_end) begin
					learning_q <= 1'b0;
				end
				if (head.op == OP_SYMBOL) begin
					if (frame_end) begin
						count_q <= '0;
						rep_hdr_q <= 1'b0;
						data_hdr_q <= 1'b0;
						shift_q <= '0;
					end else begin
						count_q <= cnt_inc;
						rep_hdr_q <= rep_nxt;
						data_hdr_q <= data_nxt;
						shift_q <= shift_nxt;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && res_valid) begin
			out_kind_q <= res_kind;
			out_code_q <= res_code;
			out_secs_q <= res_secs;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {out_secs_q, out_code_q};
	assign m_axis_tuser = out_kind_q;

endmodule

// File: src/nec_ir_receiver_with_learning.sv
// Top level of the NEC infrared receiver with learning mode.
// Holds the threshold registers and joins nir_front, nir_queue and nir_back.
// Depends on nir_pkg.
//
// The input stream carries one item per transfer: a frame symbol (mark and
// space durations in microseconds, tlast on the final symbol of a frame), a
// one-second tick, or a start-learning command, selected by tuser. The output
// stream carries at most one result per input item: a repeat code, a received
// or learned 32-bit code, a learning countdown value, or a learning timeout.
// The configuration channel writes the five duration thresholds and the
// learning timeout; it is always ready and should only be used while the
// block is idle.
//
// The block takes one item per cycle. The front end compares durations against
// the thresholds and pushes into a two-entry queue; the back end updates the
// frame and learning state and loads the output register, one queue entry per
// cycle. When the output is stalled the back end stops popping, the queue
// fills and s_axis_tready stays low until the output transfer. Reset empties
// the queue, clears the frame state, learning flag and output valid, and loads
// the default thresholds; s_axis_tready is high.
module nec_ir_receiver_with_learning #(
	parameter int unsigned MAX_SYMBOLS = nir_pkg::MAX_SYMBOLS_DEF,
	parameter int unsigned DATA_BITS = nir_pkg::DATA_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// Bits from low: mark_us[14:0], space_us[29:15], zero fill [31:30].
	input  logic [31:0]                     s_axis_tdata,
	// Bits from low: opcode[1:0].
	input  logic [1:0]                      s_axis_tuser,
	input  logic                            s_axis_tlast,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// Bits from low: code[31:0], seconds_left[39:32].
	output logic [39:0]                     m_axis_tdata,
	// Bits from low: kind[2:0].
	output logic [2:0]                      m_axis_tuser,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [nir_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [nir_pkg::DUR_W-1:0]       cfg_data
);
	import nir_pkg::*;

	nir_cfg_t   cfg_q;
	nir_item_t  push_item;
	nir_item_t  head;
	nir_qstat_t qstat;
	logic       push;
	logic       pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.repeat_mark_min <= REPEAT_MARK_RST;
			cfg_q.repeat_space_min <= REPEAT_SPACE_RST;
			cfg_q.header_mark_min <= HEADER_MARK_RST;
			cfg_q.header_space_min <= HEADER_SPACE_RST;
			cfg_q.one_space_min <= ONE_SPACE_RST;
			cfg_q.learn_timeout_seconds <= LEARN_TIMEOUT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_REPEAT_MARK: cfg_q.repeat_mark_min <= cfg_data;
				REG_REPEAT_SPACE: cfg_q.repeat_space_min <= cfg_data;
				REG_HEADER_MARK: cfg_q.header_mark_min <= cfg_data;
				REG_HEADER_SPACE: cfg_q.header_space_min <= cfg_data;
				REG_ONE_SPACE: cfg_q.one_space_min <= cfg_data;
				REG_LEARN_TIMEOUT: cfg_q.learn_timeout_seconds <= cfg_data[SEC_W-1:0];
				default: begin
				end
			endcase
		end
	end

	nir_front u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.cfg           (cfg_q),
		.qstat         (qstat),
		.push          (push),
		.push_item     (push_item)
	);

	nir_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.qstat     (qstat)
	);

	nir_back #(
		.MAX_SYMBOLS (MAX_SYMBOLS),
		.DATA_BITS   (DATA_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.head          (head),
		.qstat         (qstat),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		qstat.count <= QCNT_W'(QUEUE_DEPTH))
		else $error("Queue holds more entries than its depth.");

	a_countdown_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser == KIND_COUNTDOWN) |->
		(m_axis_tdata[31:0] == '0 && m_axis_tdata[39:32] != '0))
		else $error("Countdown result has a code or a zero count.");

	a_plain_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tuser == KIND_REPEAT || m_axis_tuser == KIND_TIMEOUT)) |->
		(m_axis_tdata == '0))
		else $error("Repeat or timeout result carries nonzero data.");

	a_code_secs: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tuser == KIND_RECEIVED || m_axis_tuser == KIND_LEARNED)) |->
		(m_axis_tdata[39:32] == '0))
		else $error("Code result carries a seconds value.");

endmodule

// File: verif/nec_ir_receiver_with_learning_tb.sv
// Self-checking testbench for nec_ir_receiver_with_learning: directed table, then random
// NEC frames, ticks and learning commands under several threshold settings.
// Depends on nir_pkg and the top level of the block.
module nec_ir_receiver_with_learning_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import nir_pkg::*;

	localparam int unsigned DATA_BITS = DATA_BITS_DEF;
	localparam int unsigned MAX_SYMBOLS = MAX_SYMBOLS_DEF;
	localparam int unsigned FRAME_SYMS = DATA_BITS + 2;
	localparam logic [DUR_W-1:0] DUR_MAX = 15'h7FFF;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int unsigned PHASES = 8;
	localparam int unsigned PHASE_ITEMS = 100;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned CYCLE_LIMIT = 600000;

	typedef struct packed {
		nir_kind_t kind;
		logic [CODE_W-1:0] code;
		logic [SEC_W-1:0] secs;
	} ir_result_t;

	typedef enum logic [1:0] {
		CHK_MODEL,
		CHK_NONE,
		CHK_RES
	} chk_t;

	typedef struct packed {
		logic [1:0] op;
		logic [DUR_W-1:0] mark;
		logic [DUR_W-1:0] space;
		logic last;
		logic [5:0] reps;
		chk_t chk;
		ir_result_t want;
	} plan_row_t;

	localparam ir_result_t NO_RES = '{KIND_REPEAT, 32'd0, 8'd0};
	localparam int unsigned PLAN_LEN = 30;
	// The typed expectation applies to the final repetition of a row only.
	localparam plan_row_t PLAN [PLAN_LEN] = '{
		'{OP_TICK,   15'd32767, 15'd32767, 1'b1, 6'd1,  CHK_NONE,  NO_RES},
		'{OP_UNUSED, 15'd32767, 15'd32767, 1'b1, 6'd1,  CHK_NONE,  NO_RES},
		'{OP_UNUSED, 15'd0,     15'd0,     1'b0, 6'd1,  CHK_NONE,  NO_RES},
		'{OP_SYMBOL, 15'd9000,  15'd2250,  1'b0, 6'd1,  CHK_NONE,  NO_RES},
		'{OP_SYMBOL, 15'd560,   15'd0,     1'b1, 6'd1,  CHK_RES,
			'{KIND_REPEAT, 32'd0, 8'd0}},
		'{OP_SYMBOL, 15'd8000,  15'd2000,  1'b0, 6'd1,  CHK_NONE,  NO_RES},
		'{OP_SYMBOL, 15'd560,   15'd560,   1'b1, 6'd1,  CHK_NONE,  NO_RES},
		'{OP_SYMBOL, 15'd0,     15'd0,     1'b1, 6'd1,  CHK_NONE,  NO_RES},
		'{OP_SYMBOL, 15'd32767, 15'd32767, 1'b0, 6'd1,  CHK_NONE,  NO_RES},
		'{OP_SYMBOL, 15'd0,     15'd0,     1'b0, 6'd1,  CHK_NONE,  NO_RES},
		'{OP_SYMBOL, 15'd0,     15'd0,     1'b1, 6'd1,  CHK_NONE,  NO_RES},
		'{OP_START,  15'd0,     15'd0,     1'b0, 6'd1,  CHK_NONE,  NO_RES},
		'{OP_TICK,   15'd0,     15'd0,     1'b0, 6'd1,  CHK_RES,
			'{KIND_COUNTDOWN, 32'd0, 8'd14}},
		'{OP_START,  15'd32767, 15'd32767, 1'b1, 6'd1,  CHK_NONE,  NO_RES},
		'{OP_TICK,   15'd0,     15'd0,     1'b0, 6'd1,  CHK_RES,
			'{KIND_COUNTDOWN, 32'd0, 8'd14}},
		'{OP_SYMBOL, 15'd9000,  15'd4500,  1'b0, 6'd1,  CHK_NONE,  NO_RES},
		'{OP_SYMBOL, 15'd560,   15'd32767, 1'b0, 6'd32, CHK_MODEL, NO_RES},
		'{OP_SYMBOL, 15'd560,   15'd0,     1'b1, 6'd1,  CHK_RES,
			'{KIND_LEARNED, 32'hFFFF_FFFF, 8'd0}},
		'{OP_TICK,   15'd0,     15'd0,     1'b0, 6'd1,  CHK_NONE,  NO_RES},
		'{OP_SYMBOL, 15'd9000,  15'd4500,  1'b0, 6'd1,  CHK_NONE,  NO_RES},
		'{OP_SYMBOL, 15'd560,   15'd1000,  1'b0, 6'd32, CHK_MODEL, NO_RES},
		'{OP_SYMBOL, 15'd560,   15'd1001,  1'b1, 6'd1,  CHK_RES,
			'{KIND_RECEIVED, 32'd0, 8'd0}},
		'{OP_SYMBOL, 15'd4001,  15'd4001,  1'b0, 6'd1,  CHK_MODEL, NO_RES},
		'{OP_SYMBOL, 15'd560,   15'd1001,  1'b0, 6'd16, CHK_MODEL, NO_RES},
		'{OP_SYMBOL, 15'd560,   15'd999,   1'b0, 6'd17, CHK_MODEL, NO_RES},
		'{OP_SYMBOL, 15'd560,   15'd0,     1'b1, 6'd1,  CHK_MODEL, NO_RES},
		'{OP_START,  15'd0,     15'd0,     1'b0, 6'd1,  CHK_NONE,  NO_RES},
		'{OP_TICK,   15'd0,     15'd0,     1'b0, 6'd14, CHK_MODEL, NO_RES},
		'{OP_TICK,   15'd0,     15'd0,     1'b0, 6'd1,  CHK_RES,
			'{KIND_TIMEOUT, 32'd0, 8'd0}},
		'{OP_TICK,   15'd0,     15'd0,     1'b1, 6'd1,  CHK_NONE,  NO_RES}
	};

	logic clk = 1'b0;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [31:0] s_axis_tdata;
	logic [1:0] s_axis_tuser;
	logic s_axis_tlast;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [39:0] m_axis_tdata;
	logic [2:0] m_axis_tuser;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DUR_W-1:0] cfg_data;

	nir_cfg_t thr;
	bit learn_on;
	logic [SEC_W-1:0] secs_left;
	logic [8:0] sym_cnt;
	bit rep_hdr;
	bit data_hdr;
	logic [CODE_W-1:0] bits_acc;

	ir_result_t pending_results [$];
	int unsigned mismatches = 0;
	int unsigned useful_items = 0;
	int unsigned cycle_count = 0;
	bit calm = 1'b0;

	nec_ir_receiver_with_learning i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic bit decode_step(input logic [1:0] op, input logic [DUR_W-1:0] mark,
			input logic [DUR_W-1:0] space, input logic last, output ir_result_t res);
		bit has;
		has = 1'b0;
		res = NO_RES;
		case (op)
			OP_TICK: begin
				if (learn_on) begin
					if (secs_left != 0)
						secs_left = secs_left - 1'b1;
					has = 1'b1;
					if (secs_left != 0) begin
						res.kind = KIND_COUNTDOWN;
						res.secs = secs_left;
					end else begin
						learn_on = 1'b0;
						res.kind = KIND_TIMEOUT;
					end
				end
			end
			OP_START: begin
				learn_on = 1'b1;
				secs_left = thr.learn_timeout_seconds;
			end
			OP_SYMBOL: begin
				if (sym_cnt == 0) begin
					rep_hdr = mark > thr.repeat_mark_min && space > thr.repeat_space_min;
					data_hdr = mark > thr.header_mark_min && space > thr.header_space_min;
				end else if (sym_cnt <= DATA_BITS && space > thr.one_space_min) begin
					bits_acc[sym_cnt - 9'd1] = 1'b1;
				end
				if (sym_cnt < MAX_SYMBOLS)
					sym_cnt = sym_cnt + 9'd1;
				if (last) begin
					if (sym_cnt == 2 && rep_hdr) begin
						has = 1'b1;
						res.kind = KIND_REPEAT;
					end else if (sym_cnt >= FRAME_SYMS && data_hdr) begin
						has = 1'b1;
						res.code = bits_acc;
						res.kind = learn_on ? KIND_LEARNED : KIND_RECEIVED;
						learn_on = 1'b0;
					end
					sym_cnt = '0;
					rep_hdr = 1'b0;
					data_hdr = 1'b0;
					bits_acc = '0;
				end
			end
			default: begin
			end
		endcase
		return has;
	endfunction

	function automatic logic [DUR_W-1:0] over(input logic [DUR_W-1:0] t);
		int unsigned hi;
		if (t == DUR_MAX)
			return t;
		if ($urandom_range(0, 3) == 0)
			return t + 1'b1;
		hi = (int'(t) + 3000 > int'(DUR_MAX)) ? int'(DUR_MAX) : int'(t) + 3000;
		return DUR_W'($urandom_range(hi, int'(t) + 1));
	endfunction

	function automatic logic [DUR_W-1:0] under(input logic [DUR_W-1:0] t);
		if ($urandom_range(0, 3) == 0)
			return t;
		return DUR_W'($urandom_range(int'(t), 0));
	endfunction

	task automatic send_item(input logic [1:0] op, input logic [DUR_W-1:0] mark,
			input logic [DUR_W-1:0] space, input logic last,
			input chk_t chk = CHK_MODEL, input ir_result_t typed = NO_RES);
		int unsigned gap;
		ir_result_t got;
		bit has;
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 16);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {2'b00, space, mark};
		s_axis_tuser <= op;
		s_axis_tlast <= last;
		do @(posedge clk); while (!s_axis_tready);
		if (op == OP_SYMBOL || op == OP_START || (op == OP_TICK && learn_on))
			useful_items++;
		has = decode_step(op, mark, space, last, got);
		case (chk)
			CHK_MODEL: if (has) pending_results.push_back(got);
			CHK_RES: pending_results.push_back(typed);
			default: begin
			end
		endcase
	endtask

	task automatic drain(input int unsigned extra);
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_reg(input nir_reg_t idx, input logic [DUR_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_REPEAT_MARK: thr.repeat_mark_min = val;
			REG_REPEAT_SPACE: thr.repeat_space_min = val;
			REG_HEADER_MARK: thr.header_mark_min = val;
			REG_HEADER_SPACE: thr.header_space_min = val;
			REG_ONE_SPACE: thr.one_space_min = val;
			REG_LEARN_TIMEOUT: thr.learn_timeout_seconds = val[SEC_W-1:0];
			default: begin
			end
		endcase
	endtask

	task automatic send_data_frame(input bit long_frame);
		int unsigned nsym;
		int unsigned pick;
		logic [DUR_W-1:0] hm;
		logic [DUR_W-1:0] hs;
		logic [DUR_W-1:0] sp;
		if (long_frame) begin
			nsym = $urandom_range(MAX_SYMBOLS + 1, MAX_SYMBOLS + 44);
		end else begin
			pick = $urandom_range(0, 9);
			if (pick < 6)
				nsym = FRAME_SYMS;
			else if (pick < 8)
				nsym = $urandom_range(FRAME_SYMS + 1, FRAME_SYMS + 6);
			else
				nsym = $urandom_range(2, FRAME_SYMS - 1);
		end
		hm = over(thr.header_mark_min);
		hs = over(thr.header_space_min);
		if ($urandom_range(0, 7) == 0) begin
			if ($urandom_range(0, 1))
				hm = under(thr.header_mark_min);
			else
				hs = under(thr.header_space_min);
		end
		send_item(OP_SYMBOL, hm, hs, nsym == 1);
		for (int i = 1; i < nsym; i++) begin
			if ($urandom_range(0, 39) == 0)
				send_item($urandom_range(0, 1) ? OP_TICK : OP_START,
					DUR_W'($urandom_range(0, 32767)), DUR_W'($urandom_range(0, 32767)),
					1'($urandom_range(0, 1)));
			sp = $urandom_range(0, 1) ? over(thr.one_space_min) : under(thr.one_space_min);
			send_item(OP_SYMBOL, DUR_W'($urandom_range(0, 2000)), sp, i == nsym - 1);
		end
	endtask

	task automatic send_repeat_frame();
		int unsigned nsym;
		logic [DUR_W-1:0] hm;
		logic [DUR_W-1:0] hs;
		nsym = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 2;
		hm = over(thr.repeat_mark_min);
		hs = over(thr.repeat_space_min);
		if ($urandom_range(0, 7) == 0) begin
			if ($urandom_range(0, 1))
				hm = under(thr.repeat_mark_min);
			else
				hs = under(thr.repeat_space_min);
		end
		send_item(OP_SYMBOL, hm, hs, nsym == 1);
		for (int i = 1; i < nsym; i++)
			send_item(OP_SYMBOL, DUR_W'($urandom_range(0, 2000)),
				DUR_W'($urandom_range(0, 32767)), i == nsym - 1);
	endtask

	initial begin : sink_ctl
		int unsigned hold;
		m_axis_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (calm) begin
				m_axis_tready <= 1'b1;
			end else begin
				hold = $urandom_range(1, 16);
				if ($urandom_range(0, 7) == 0) begin
					m_axis_tready <= 1'b1;
					hold = $urandom_range(64, 200);
				end else begin
					m_axis_tready <= ($urandom_range(0, 2) != 0);
				end
				repeat (hold - 1) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin : result_check
		ir_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected result: kind %0d code %h seconds %0d",
						m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[39:32]);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				if (m_axis_tuser !== want.kind || m_axis_tdata[31:0] !== want.code ||
						m_axis_tdata[39:32] !== want.secs) begin
					if (mismatches < 10)
						$display("result mismatch: kind %0d/%0d code %h/%h seconds %0d/%0d",
							want.kind, m_axis_tuser, want.code, m_axis_tdata[31:0],
							want.secs, m_axis_tdata[39:32]);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin : stimulus
		int unsigned phase_start;
		int unsigned sel;
		bit paused;
		logic [DUR_W-1:0] rm, rs, hm, hs, one, lt;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = OP_SYMBOL;
		s_axis_tlast = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_REPEAT_MARK;
		cfg_data = '0;
		paused = 1'b0;
		thr = '{REPEAT_MARK_RST, REPEAT_SPACE_RST, HEADER_MARK_RST, HEADER_SPACE_RST,
			ONE_SPACE_RST, LEARN_TIMEOUT_RST};
		learn_on = 1'b0;
		secs_left = COUNTDOWN_RST;
		sym_cnt = '0;
		rep_hdr = 1'b0;
		data_hdr = 1'b0;
		bits_acc = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < PLAN_LEN; i++)
			for (int k = 0; k < PLAN[i].reps; k++)
				if (k == PLAN[i].reps - 1)
					send_item(PLAN[i].op, PLAN[i].mark, PLAN[i].space, PLAN[i].last,
						PLAN[i].chk, PLAN[i].want);
				else
					send_item(PLAN[i].op, PLAN[i].mark, PLAN[i].space, 1'b0);

		for (int p = 0; p < PHASES; p++) begin
			drain(SETTLE_CYCLES);
			if (p == 0) begin
				{rm, rs, hm, hs, one} = '0;
				lt = 15'd1;
			end else if (p == 1) begin
				{rm, rs, hm, hs, one} = {5{DUR_MAX}};
				lt = 15'd255;
			end else if (p == PHASES - 1) begin
				{rm, rs, hm, hs, one} = {REPEAT_MARK_RST, REPEAT_SPACE_RST, HEADER_MARK_RST,
					HEADER_SPACE_RST, ONE_SPACE_RST};
				lt = 15'(LEARN_TIMEOUT_RST);
				calm = 1'b1;
			end else begin
				rm = DUR_W'($urandom_range(0, 12000));
				rs = DUR_W'($urandom_range(0, 5000));
				hm = DUR_W'($urandom_range(0, 9000));
				hs = DUR_W'($urandom_range(0, 6000));
				one = DUR_W'($urandom_range(0, 3000));
				lt = DUR_W'($urandom_range(1, 20));
			end
			write_reg(REG_REPEAT_MARK, rm);
			write_reg(REG_REPEAT_SPACE, rs);
			write_reg(REG_HEADER_MARK, hm);
			write_reg(REG_HEADER_SPACE, hs);
			write_reg(REG_ONE_SPACE, one);
			write_reg(REG_LEARN_TIMEOUT, lt);
			cfg_valid <= 1'b0;

			phase_start = useful_items;
			if (p % 3 == 1)
				send_data_frame(1'b1);
			while (useful_items - phase_start < PHASE_ITEMS) begin
				if (p == 3 && !paused && useful_items - phase_start >= PHASE_ITEMS / 2) begin
					drain(1);
					paused = 1'b1;
				end
				sel = $urandom_range(0, 99);
				if (sel < 45)
					send_data_frame(1'b0);
				else if (sel < 60)
					send_repeat_frame();
				else if (sel < 72)
					send_item(OP_TICK, DUR_W'($urandom_range(0, 32767)),
						DUR_W'($urandom_range(0, 32767)), 1'($urandom_range(0, 1)));
				else if (sel < 78)
					send_item(OP_START, DUR_W'($urandom_range(0, 32767)),
						DUR_W'($urandom_range(0, 32767)), 1'($urandom_range(0, 1)));
				else if (sel < 92)
					send_item(OP_SYMBOL, DUR_W'($urandom_range(0, 32767)),
						DUR_W'($urandom_range(0, 32767)), $urandom_range(0, 2) == 0);
				else
					send_item(OP_UNUSED, DUR_W'($urandom_range(0, 32767)),
						DUR_W'($urandom_range(0, 32767)), 1'($urandom_range(0, 1)));
			end
		end

		drain(20);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule

// File: filelist.f
src/nir_pkg.sv
src/nir_front.sv
src/nir_queue.sv
src/nir_back.sv
src/nec_ir_receiver_with_learning.sv
verif/nec_ir_receiver_with_learning_tb.sv
